// ===== hdl/ffba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared constants and codes of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

	localparam int ARENA_BYTES  = 4096;
	localparam int START_OFFSET = 2;
	localparam int HDR_DEPTH    = ARENA_BYTES / 2;
	localparam int HDR_AW       = $clog2(HDR_DEPTH);

	localparam logic [15:0] ARENA     = 16'(ARENA_BYTES);
	localparam logic [15:0] START     = 16'(START_OFFSET);
	localparam logic [15:0] MAX_BLOCK = 16'h7ffc;
	localparam logic [15:0] MIN_SPLIT = 16'd6;
	localparam logic [15:0] INIT_LEN  = 16'((ARENA_BYTES - START_OFFSET) / 2 * 2);
	localparam logic [15:0] INIT_HDR  = 16'd0 - INIT_LEN;

	localparam logic [1:0] CMD_ALLOC  = 2'd0;
	localparam logic [1:0] CMD_FREE   = 2'd1;
	localparam logic [1:0] CMD_RESIZE = 2'd2;
	localparam logic [1:0] CMD_INIT   = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_IGNORED = 2'd2;

endpackage

// ===== hdl/ffba_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffba_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hdl/first_fit_block_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator over block headers of a fixed arena, held in one RAM.
// ----------------------------------------------------------------------------
// Raise start with a command while busy is low; one result comes back, marked
// by a one-cycle done strobe, and must be taken in that cycle. Every header
// visit is a registered RAM read followed by an evaluate step, in the
// first-fit walk, hint walk, coalescing pass and absorb loop; an invalid
// free or resize is answered with the ignored status. After reset the block
// writes the initial free header before it accepts a command.
// ----------------------------------------------------------------------------
module first_fit_block_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [11:0] req_size,
	input  logic [11:0] payload_offset,
	input  logic        has_buffer,
	output logic        done,
	output logic [1:0]  status,
	output logic [11:0] result_offset,
	output logic        moved,
	output logic [11:0] copy_bytes
);

	typedef enum logic [18:0] {
		S_IDLE     = 19'h00001,
		S_INIT     = 19'h00002,
		S_FF_START = 19'h00004,
		S_FF_RD    = 19'h00008,
		S_FF_EV    = 19'h00010,
		S_T_WR     = 19'h00020,
		S_TB_RD    = 19'h00040,
		S_TB_EV    = 19'h00080,
		S_CO_RD    = 19'h00100,
		S_CO_EV    = 19'h00200,
		S_CO_EV2   = 19'h00400,
		S_FF_OK    = 19'h00800,
		S_AFAIL    = 19'h01000,
		S_V_RD     = 19'h02000,
		S_V_EV     = 19'h04000,
		S_RA_CHK   = 19'h08000,
		S_RA_EV    = 19'h10000,
		S_RA_END   = 19'h20000,
		S_RA_SPLIT = 19'h40000
	} state_t;

	localparam logic [15:0] MAX_BLOCK_C = ffba_pkg::MAX_BLOCK;

	state_t state_q, tb_ret_q;

	logic [1:0]  cmd_q;
	logic [11:0] size_q, pay_q;
	logic        has_q, req_live_q, retry_q;
	logic [11:0] hint_q;
	logic        hint_v_q;
	logic [15:0] off_q, need_q, tb_off_q, tb_val_q, tb_cur_q;
	logic [15:0] co_h_q, co_m_q;
	logic [15:0] ro_off_q, ro_cur_q, old_len_q, sz_q;
	logic        rd_oob_q;

	logic        done_q;
	logic [1:0]  status_q;
	logic [11:0] res_q, copy_q;
	logic        moved_q;

	// RAM ports
	logic        ram_we;
	logic [15:0] ram_wa, ram_wd, ram_ra, ram_rd;

	// Header just read, with out-of-arena reads as zero
	logic [15:0] h, hmag;
	logic        hneg;
	logic [15:0] size2, sz_c, ra_next, ra_sum, co_sum, need_c, hint_ext;
	logic        ff_fit, merge, ra_go, absorb, fits_in_place, split_ok;
	logic        is_resize, pay_ok;

	assign h        = rd_oob_q ? 16'd0 : ram_rd;
	assign hneg     = h[15];
	assign hmag     = hneg ? (16'd0 - h) : h;
	assign hint_ext = {4'd0, hint_q};

	assign size2   = {4'd0, size_q} + 16'd2;
	assign need_c  = {4'd0, size_q} + {14'd0, (2'd2 - size_q[1:0])} + 16'd2;
	assign sz_c    = (size2 + 16'd3) & ~16'd3;
	assign ff_fit  = hneg && (hmag >= need_q);
	assign co_sum  = co_m_q + hmag;
	assign merge   = hneg && (co_sum <= MAX_BLOCK_C);
	assign ra_next = ro_off_q + ro_cur_q;
	assign ra_go   = (ra_next < ffba_pkg::ARENA) && (ro_cur_q < size2);
	assign ra_sum  = ro_cur_q + hmag;
	assign absorb  = hneg && (ra_sum <= MAX_BLOCK_C);
	assign fits_in_place = ro_cur_q >= size2;
	assign split_ok = (ro_cur_q >= sz_c) && ((ro_cur_q - sz_c) >= ffba_pkg::MIN_SPLIT);
	assign is_resize = (cmd_q == ffba_pkg::CMD_RESIZE) && has_q;
	assign pay_ok = !payload_offset[0]
		&& ({4'd0, payload_offset} >= (ffba_pkg::START + 16'd2))
		&& ({4'd0, payload_offset} < ffba_pkg::ARENA);

	// Drive the RAM ports from the current step
	always_comb begin
		ram_we = 1'b0;
		ram_wa = ro_off_q;
		ram_wd = 16'd0;
		ram_ra = off_q;
		case (state_q)
			S_INIT: begin
				ram_we = 1'b1;
				ram_wa = ffba_pkg::START;
				ram_wd = ffba_pkg::INIT_HDR;
			end
			S_FF_EV: begin
				if (ff_fit && hmag != need_q) begin
					ram_we = 1'b1;
					ram_wa = off_q + need_q;
					ram_wd = need_q - hmag;
				end
			end
			S_T_WR: begin
				ram_we = 1'b1;
				ram_wa = tb_off_q;
				ram_wd = tb_val_q;
			end
			S_TB_RD: ram_ra = tb_cur_q;
			S_CO_EV: ram_ra = off_q + hmag;
			S_CO_EV2: begin
				if (merge) begin
					ram_we = 1'b1;
					ram_wa = off_q;
					ram_wd = co_h_q + h;
				end
			end
			S_FF_OK: begin
				if (is_resize) begin
					ram_we = 1'b1;
					ram_wd = 16'd0 - ro_cur_q;
				end
			end
			S_V_RD: ram_ra = ro_off_q;
			S_V_EV: begin
				if (!hneg && h != 16'd0 && cmd_q == ffba_pkg::CMD_FREE) begin
					ram_we = 1'b1;
					ram_wd = 16'd0 - h;
				end
			end
			S_RA_CHK: ram_ra = ra_next;
			S_RA_EV: begin
				if (absorb) begin
					ram_we = 1'b1;
					ram_wd = ra_sum;
				end
			end
			S_RA_END: begin
				if (fits_in_place && split_ok) begin
					ram_we = 1'b1;
					ram_wd = sz_c;
				end
			end
			S_RA_SPLIT: begin
				ram_we = 1'b1;
				ram_wa = ro_off_q + sz_q;
				ram_wd = sz_q - ro_cur_q;
			end
			default: ;
		endcase
	end

	ffba_ram #(
		.WIDTH(16),
		.DEPTH(ffba_pkg::HDR_DEPTH)
	) u_hdr_ram (
		.clk  (clk),
		.we   (ram_we && (ram_wa < ffba_pkg::ARENA)),
		.waddr(ram_wa[ffba_pkg::HDR_AW:1]),
		.wdata(ram_wd),
		.raddr(ram_ra[ffba_pkg::HDR_AW:1]),
		.rdata(ram_rd)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_INIT;
			tb_ret_q   <= S_IDLE;
			req_live_q <= 1'b0;
			retry_q    <= 1'b0;
			hint_q     <= ffba_pkg::START[11:0];
			hint_v_q   <= 1'b1;
			done_q     <= 1'b0;
			rd_oob_q   <= 1'b0;
		end else begin
			done_q   <= 1'b0;
			rd_oob_q <= ram_ra >= ffba_pkg::ARENA;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q      <= cmd;
						size_q     <= req_size;
						pay_q      <= payload_offset;
						has_q      <= has_buffer;
						req_live_q <= 1'b1;
						retry_q    <= 1'b0;
						ro_off_q   <= {4'd0, payload_offset} - 16'd2;
						if (cmd == ffba_pkg::CMD_INIT) begin
							state_q <= S_INIT;
						end else if (cmd == ffba_pkg::CMD_ALLOC
							|| (cmd == ffba_pkg::CMD_RESIZE && !has_buffer)) begin
							state_q <= S_FF_START;
						end else if (!has_buffer || !pay_ok) begin
							done_q     <= 1'b1;
							req_live_q <= 1'b0;
							status_q   <= ffba_pkg::ST_IGNORED;
							res_q      <= 12'd0;
							moved_q    <= 1'b0;
							copy_q     <= 12'd0;
						end else begin
							state_q <= S_V_RD;
						end
					end
				end
				S_INIT: begin
					hint_q   <= ffba_pkg::START[11:0];
					hint_v_q <= 1'b1;
					state_q  <= S_IDLE;
					if (req_live_q) begin
						done_q     <= 1'b1;
						req_live_q <= 1'b0;
						status_q   <= ffba_pkg::ST_OK;
						res_q      <= 12'd0;
						moved_q    <= 1'b0;
						copy_q     <= 12'd0;
					end
				end
				// First-fit walk from the hint
				S_FF_START: begin
					need_q <= need_c;
					off_q  <= hint_ext;
					if (hint_v_q) begin
						state_q <= S_FF_RD;
					end else if (retry_q) begin
						state_q <= S_AFAIL;
					end else begin
						off_q   <= ffba_pkg::START;
						retry_q <= 1'b1;
						state_q <= S_CO_RD;
					end
				end
				S_FF_RD: begin
					if (off_q < ffba_pkg::ARENA) begin
						state_q <= S_FF_EV;
					end else if (retry_q) begin
						state_q <= S_AFAIL;
					end else begin
						off_q   <= ffba_pkg::START;
						retry_q <= 1'b1;
						state_q <= S_CO_RD;
					end
				end
				S_FF_EV: begin
					if (hmag == 16'd0) begin
						if (retry_q) begin
							state_q <= S_AFAIL;
						end else begin
							off_q   <= ffba_pkg::START;
							retry_q <= 1'b1;
							state_q <= S_CO_RD;
						end
					end else if (ff_fit) begin
						tb_off_q <= off_q;
						tb_val_q <= need_q;
						tb_ret_q <= S_FF_OK;
						state_q  <= S_T_WR;
					end else begin
						off_q   <= off_q + hmag;
						state_q <= S_FF_RD;
					end
				end
				// Mark a block used and move the hint past it if needed
				S_T_WR: begin
					tb_cur_q <= tb_off_q;
					if (hint_v_q && hint_ext == tb_off_q) begin
						state_q <= S_TB_RD;
					end else begin
						state_q <= tb_ret_q;
					end
				end
				S_TB_RD: state_q <= S_TB_EV;
				S_TB_EV: begin
					if (hneg) begin
						hint_q  <= tb_cur_q[11:0];
						state_q <= tb_ret_q;
					end else if (hmag == 16'd0
						|| (tb_cur_q + hmag) >= ffba_pkg::ARENA) begin
						hint_v_q <= 1'b0;
						state_q  <= tb_ret_q;
					end else begin
						tb_cur_q <= tb_cur_q + hmag;
						state_q  <= S_TB_RD;
					end
				end
				// Coalescing pass over the whole arena
				S_CO_RD: begin
					state_q <= (off_q < ffba_pkg::ARENA) ? S_CO_EV : S_FF_START;
				end
				S_CO_EV: begin
					co_h_q <= h;
					co_m_q <= hmag;
					if (hmag == 16'd0 || (off_q + hmag) >= ffba_pkg::ARENA) begin
						state_q <= S_FF_START;
					end else if (hneg) begin
						state_q <= S_CO_EV2;
					end else begin
						off_q   <= off_q + hmag;
						state_q <= S_CO_RD;
					end
				end
				S_CO_EV2: begin
					if (!merge) begin
						off_q <= off_q + co_m_q;
					end
					state_q <= S_CO_RD;
				end
				S_FF_OK: begin
					done_q     <= 1'b1;
					req_live_q <= 1'b0;
					state_q    <= S_IDLE;
					status_q   <= ffba_pkg::ST_OK;
					res_q      <= 12'(off_q + 16'd2);
					moved_q    <= is_resize;
					copy_q     <= is_resize ? old_len_q[11:0] : 12'd0;
					if (is_resize && (!hint_v_q || hint_ext > ro_off_q)) begin
						hint_q   <= ro_off_q[11:0];
						hint_v_q <= 1'b1;
					end
				end
				S_AFAIL: begin
					done_q     <= 1'b1;
					req_live_q <= 1'b0;
					state_q    <= S_IDLE;
					status_q   <= ffba_pkg::ST_NOSPACE;
					res_q      <= 12'd0;
					moved_q    <= 1'b0;
					copy_q     <= 12'd0;
				end
				// Check the header of an existing block, and free it for a free command
				S_V_RD: state_q <= S_V_EV;
				S_V_EV: begin
					ro_cur_q  <= h;
					old_len_q <= h - 16'd2;
					if (hneg || h == 16'd0) begin
						done_q     <= 1'b1;
						req_live_q <= 1'b0;
						state_q    <= S_IDLE;
						status_q   <= ffba_pkg::ST_IGNORED;
						res_q      <= 12'd0;
						moved_q    <= 1'b0;
						copy_q     <= 12'd0;
					end else if (cmd_q == ffba_pkg::CMD_FREE) begin
						done_q     <= 1'b1;
						req_live_q <= 1'b0;
						state_q    <= S_IDLE;
						status_q   <= ffba_pkg::ST_OK;
						res_q      <= 12'd0;
						moved_q    <= 1'b0;
						copy_q     <= 12'd0;
						if (!hint_v_q || hint_ext > ro_off_q) begin
							hint_q   <= ro_off_q[11:0];
							hint_v_q <= 1'b1;
						end
					end else begin
						state_q <= S_RA_CHK;
					end
				end
				// Absorb following free blocks for resize
				S_RA_CHK: state_q <= ra_go ? S_RA_EV : S_RA_END;
				S_RA_EV: begin
					if (absorb) begin
						ro_cur_q <= ra_sum;
						tb_off_q <= ra_next;
						tb_val_q <= hmag;
						tb_ret_q <= S_RA_CHK;
						state_q  <= S_T_WR;
					end else begin
						state_q <= S_RA_END;
					end
				end
				S_RA_END: begin
					sz_q <= sz_c;
					if (!fits_in_place) begin
						retry_q <= 1'b0;
						state_q <= S_FF_START;
					end else if (split_ok) begin
						state_q <= S_RA_SPLIT;
					end else begin
						done_q     <= 1'b1;
						req_live_q <= 1'b0;
						state_q    <= S_IDLE;
						status_q   <= ffba_pkg::ST_OK;
						res_q      <= pay_q;
						moved_q    <= 1'b0;
						copy_q     <= 12'd0;
					end
				end
				S_RA_SPLIT: begin
					done_q     <= 1'b1;
					req_live_q <= 1'b0;
					state_q    <= S_IDLE;
					status_q   <= ffba_pkg::ST_OK;
					res_q      <= pay_q;
					moved_q    <= 1'b0;
					copy_q     <= 12'd0;
					if (!hint_v_q || hint_ext > (ro_off_q + sz_q)) begin
						hint_q   <= 12'(ro_off_q + sz_q);
						hint_v_q <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy          = state_q != S_IDLE;
	assign done          = done_q;
	assign status        = status_q;
	assign result_offset = res_q;
	assign moved         = moved_q;
	assign copy_bytes    = copy_q;

`ifndef ASSERT_OFF
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while sequencer still busy");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ffba_pkg::ST_OK |-> result_offset == 12'd0 && !moved)
		else $error("failed transaction carries an offset or move");
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("accepted transaction neither busy nor answered");
	a_moved_resize: assert property (@(posedge clk) disable iff (!arst_n)
		done && moved |-> cmd_q == ffba_pkg::CMD_RESIZE)
		else $error("move reported for a non-resize transaction");
`endif

endmodule
